>>> src/psr_pkg.sv
// ----------------------------------------------------------------------------
// psr_pkg
// Shared types and constants of the peer SNR ranker.
// ----------------------------------------------------------------------------
package psr_pkg;

	localparam int PEER_CAPACITY = 32;
	localparam int SHOWN_ROWS    = 8;
	localparam int BAR_STEPS     = 8;

	localparam int HELD_W = $clog2(PEER_CAPACITY + 1);

	localparam logic signed [31:0] SNR_UNKNOWN  = 32'sh8000_0000;
	localparam logic signed [31:0] SNR_LOW      = -32'sd1000;
	localparam logic signed [31:0] SNR_HIGH     = 32'sd1000;
	localparam logic [7:0]         HOPS_UNKNOWN = 8'hFF;

	localparam logic [2:0] UNIT_SEC     = 3'd0;
	localparam logic [2:0] UNIT_MIN     = 3'd1;
	localparam logic [2:0] UNIT_HOUR    = 3'd2;
	localparam logic [2:0] UNIT_DAY     = 3'd3;
	localparam logic [2:0] UNIT_UNKNOWN = 3'd4;

	localparam logic [16:0] SEC_MIN  = 17'd60;
	localparam logic [16:0] SEC_HOUR = 17'd3600;
	localparam logic [16:0] SEC_DAY  = 17'd86400;

	localparam logic [31:0] RECIP_MIN  = 32'((64'd1 << 32) / 60);
	localparam logic [31:0] RECIP_HOUR = 32'((64'd1 << 32) / 3600);
	localparam logic [31:0] RECIP_DAY  = 32'((64'd1 << 32) / 86400);

	localparam int          BAR_SH    = 28;
	localparam logic [17:0] BAR_RECIP = 18'(((64'd1 << BAR_SH) + 1999) / 2000);
	localparam logic [6:0]  BAR_FULL  = 7'(BAR_STEPS);

	localparam logic [2:0] REG_OWN_ID    = 3'd0;
	localparam logic [2:0] REG_OWN_VALID = 3'd4;

	typedef struct packed {
		logic               valid;
		logic [31:0]        id;
		logic signed [31:0] snr;
		logic [7:0]         hops;
		logic [31:0]        heard;
	} rec_t;

	typedef struct packed {
		logic ins;
		logic shift;
	} cell_ctl_t;

endpackage

>>> src/psr_cell.sv
// ----------------------------------------------------------------------------
// psr_cell
// One slot of the ranking chain: keeps, takes the new record or the upper
// neighbor's record on insert, takes the lower neighbor's record on shift.
// ----------------------------------------------------------------------------
module psr_cell
	import psr_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  rec_t      new_rec,
	input  rec_t      upper_rec,
	input  logic      upper_keep,
	input  rec_t      lower_rec,
	output rec_t      rec,
	output logic      keep
);

	rec_t rec_q;

	assign rec  = rec_q;
	assign keep = rec_q.valid && (rec_q.snr >= new_rec.snr);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_q <= '0;
		end else if (ctl.shift) begin
			rec_q <= lower_rec;
		end else if (ctl.ins && !keep) begin
			if (upper_keep) begin
				rec_q <= new_rec;
			end else begin
				rec_q <= upper_rec;
			end
		end
	end

endmodule

>>> src/psr_fmt.sv
// ----------------------------------------------------------------------------
// psr_fmt
// Three-stage formatter: bar level and age with unit for one ranked record.
// ----------------------------------------------------------------------------
module psr_fmt
	import psr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  rec_t        rec,
	input  logic [31:0] newest,
	output logic        done,
	output logic [3:0]  bar_level,
	output logic [15:0] age_amount,
	output logic [2:0]  age_unit
);

	logic v_s1, v_s2, v_s3;
	logic [31:0] age_s1, age_s2;
	logic [2:0]  unit_s1, unit_s2, unit_s3;
	logic [16:0] div_s1, div_s2;
	logic [31:0] recip_s1;
	logic [3:0]  bar_s1, bar_s2, bar_s3;
	logic [31:0] q_s2;
	logic [15:0] amt_s3;

	logic [31:0] age_c;
	logic [2:0]  unit_c;
	logic [16:0] div_c;
	logic [31:0] recip_c;
	logic [10:0] bar_off;
	logic [16:0] bar_prod;
	logic [35:0] bar_q;
	logic [6:0]  bar_c;
	logic [63:0] qprod;
	logic [48:0] qd;
	logic [31:0] rem;
	logic [31:0] q_fix;

	always_comb begin
		age_c   = newest - rec.heard;
		div_c   = SEC_MIN;
		recip_c = RECIP_MIN;
		if (newest == 32'd0 || rec.heard == 32'd0 || rec.heard > newest) begin
			unit_c = UNIT_UNKNOWN;
		end else if (age_c < 32'(SEC_MIN)) begin
			unit_c = UNIT_SEC;
		end else if (age_c < 32'(SEC_HOUR)) begin
			unit_c = UNIT_MIN;
		end else if (age_c < 32'(SEC_DAY)) begin
			unit_c  = UNIT_HOUR;
			div_c   = SEC_HOUR;
			recip_c = RECIP_HOUR;
		end else begin
			unit_c  = UNIT_DAY;
			div_c   = SEC_DAY;
			recip_c = RECIP_DAY;
		end
		bar_off  = 11'(rec.snr + 32'sd1000);
		bar_prod = 17'(bar_off) * 17'(BAR_STEPS);
		bar_q    = 36'(bar_prod) * 36'(BAR_RECIP);
		if (rec.snr <= SNR_LOW) begin
			bar_c = 7'd0;
		end else if (rec.snr >= SNR_HIGH) begin
			bar_c = BAR_FULL;
		end else begin
			bar_c = bar_q[BAR_SH +: 7];
		end
	end

	assign qprod = 64'(age_s1) * 64'(recip_s1);
	assign qd    = 49'(q_s2) * 49'(div_s2);
	assign rem   = age_s2 - qd[31:0];

	always_comb begin
		q_fix = q_s2;
		if (rem >= 32'(div_s2)) begin
			q_fix = q_s2 + 32'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		age_s1   <= age_c;
		unit_s1  <= unit_c;
		div_s1   <= div_c;
		recip_s1 <= recip_c;
		bar_s1   <= bar_c[3:0];

		age_s2  <= age_s1;
		unit_s2 <= unit_s1;
		div_s2  <= div_s1;
		bar_s2  <= bar_s1;
		q_s2    <= qprod[63:32];

		unit_s3 <= unit_s2;
		bar_s3  <= bar_s2;
		case (unit_s2) inside
			UNIT_SEC: amt_s3 <= age_s2[15:0];
			UNIT_MIN, UNIT_HOUR, UNIT_DAY: amt_s3 <= q_fix[15:0];
			default: amt_s3 <= 16'd0;
		endcase
	end

	assign done       = v_s3;
	assign bar_level  = bar_s3;
	assign age_amount = amt_s3;
	assign age_unit   = unit_s3;

endmodule

>>> src/peer_snr_ranker_top.sv
// ----------------------------------------------------------------------------
// peer_snr_ranker_top
// Collects peer records into a ranking chain and emits the strongest rows.
//
// channel   dir  transaction
// s_axis    in   load record (tuser 0) or finish (tuser 1)
// m_axis    out  one ranked row, tlast on the final row
// apb       in   own_node_id at 0x0, own_id_valid at 0x4
//
// On a load every chain cell compares and inserts in parallel.
// A finish walks each row through LAUNCH, the three-stage age/bar formatter and
// SEND; a row waits in SEND while the sink stalls, and the next row starts once it is taken.
// Reset clears the chain valids and counters; no clearing pass is needed.
// s_axis_tready is low while a finish run is in progress.
// ----------------------------------------------------------------------------
module peer_snr_ranker_top
	import psr_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	// peer_id[31:0], snr_hundredths[63:32], hop_count[71:64], heard_time[103:72]
	input  logic [103:0]  s_axis_tdata,
	// cmd[0]
	input  logic          s_axis_tuser,
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	// rank[2:0], out_peer_id[34:3], out_snr[66:35], bar_level[70:67],
	// out_hops[78:71], age_amount[94:79], age_unit[97:95], peer_total[103:98]
	output logic [103:0]  m_axis_tdata,
	output logic          m_axis_tlast,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [2:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);

	typedef enum logic [1:0] {IDLE, LAUNCH, FMT, SEND} state_t;

	state_t state_q;

	logic [31:0] own_id_q;
	logic        own_valid_q;
	logic [HELD_W-1:0] held_q;
	logic [31:0] newest_q;
	logic [31:0] ref_q;
	logic [5:0]  total_q;
	logic [2:0]  rank_q;

	logic [31:0]        o_id_q;
	logic signed [31:0] o_snr_q;
	logic [3:0]         o_bar_q;
	logic [7:0]         o_hops_q;
	logic [15:0]        o_amt_q;
	logic [2:0]         o_unit_q;
	logic               o_last_q;
	logic               o_valid_q;

	rec_t      new_rec;
	rec_t      chain [SHOWN_ROWS+1];
	logic      keeps [SHOWN_ROWS+1];
	cell_ctl_t ctl;
	logic in_acc, out_acc, is_load, take;

	logic        f_done;
	logic [3:0]  f_bar;
	logic [15:0] f_amt;
	logic [2:0]  f_unit;

	assign pready = 1'b1;
	always_comb begin
		unique case (paddr)
			REG_OWN_ID:    prdata = own_id_q;
			REG_OWN_VALID: prdata = {31'd0, own_valid_q};
			default:       prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_id_q    <= 32'd0;
			own_valid_q <= 1'b0;
		end else if (psel && penable && pwrite) begin
			if (paddr == REG_OWN_ID) own_id_q <= pwdata;
			if (paddr == REG_OWN_VALID) own_valid_q <= pwdata[0];
		end
	end

	assign s_axis_tready = (state_q == IDLE);
	assign in_acc  = s_axis_tvalid && s_axis_tready;
	assign out_acc = m_axis_tvalid && m_axis_tready;
	assign is_load = !s_axis_tuser;

	assign new_rec.valid = 1'b1;
	assign new_rec.id    = s_axis_tdata[31:0];
	assign new_rec.snr   = s_axis_tdata[63:32];
	assign new_rec.hops  = s_axis_tdata[71:64];
	assign new_rec.heard = s_axis_tdata[103:72];

	assign take = in_acc && is_load && (held_q < HELD_W'(PEER_CAPACITY))
		&& !(own_valid_q && new_rec.id == own_id_q) && (new_rec.snr != SNR_UNKNOWN);

	assign ctl.ins   = take;
	assign ctl.shift = out_acc;

	assign keeps[0] = 1'b1;
	assign chain[SHOWN_ROWS] = '0;

	for (genvar i = 0; i < SHOWN_ROWS; i++) begin : g_cell
		rec_t cell_rec;
		logic cell_keep;
		psr_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.new_rec    (new_rec),
			.upper_rec  (chain[(i == 0) ? 0 : i - 1]),
			.upper_keep (keeps[i]),
			.lower_rec  (chain[i+1]),
			.rec        (cell_rec),
			.keep       (cell_keep)
		);
		assign chain[i]  = cell_rec;
		assign keeps[i+1] = cell_keep;
	end

	psr_fmt u_fmt (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (state_q == LAUNCH),
		.rec        (chain[0]),
		.newest     (ref_q),
		.done       (f_done),
		.bar_level  (f_bar),
		.age_amount (f_amt),
		.age_unit   (f_unit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= IDLE;
			held_q    <= '0;
			newest_q  <= 32'd0;
			o_valid_q <= 1'b0;
			rank_q    <= 3'd0;
		end else begin
			unique case (state_q)
				IDLE: begin
					if (take) begin
						held_q <= held_q + HELD_W'(1);
						if (new_rec.heard > newest_q) newest_q <= new_rec.heard;
					end
					if (in_acc && !is_load) begin
						held_q   <= '0;
						newest_q <= 32'd0;
						rank_q   <= 3'd0;
						if (chain[0].valid) begin
							state_q <= LAUNCH;
						end else begin
							o_valid_q <= 1'b1;
							state_q   <= SEND;
						end
					end
				end
				LAUNCH: state_q <= FMT;
				FMT: begin
					if (f_done) begin
						o_valid_q <= 1'b1;
						state_q   <= SEND;
					end
				end
				SEND: begin
					if (out_acc) begin
						o_valid_q <= 1'b0;
						rank_q    <= rank_q + 3'd1;
						state_q   <= o_last_q ? IDLE : LAUNCH;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == IDLE && in_acc && !is_load) begin
			ref_q    <= newest_q;
			total_q  <= 6'(held_q);
			o_id_q   <= 32'd0;
			o_snr_q  <= SNR_UNKNOWN;
			o_bar_q  <= 4'd0;
			o_hops_q <= HOPS_UNKNOWN;
			o_amt_q  <= 16'd0;
			o_unit_q <= UNIT_UNKNOWN;
			o_last_q <= 1'b1;
		end else if (state_q == FMT && f_done) begin
			o_id_q   <= chain[0].id;
			o_snr_q  <= chain[0].snr;
			o_bar_q  <= f_bar;
			o_hops_q <= chain[0].hops;
			o_amt_q  <= f_amt;
			o_unit_q <= f_unit;
			o_last_q <= !chain[1].valid;
		end
	end

	assign m_axis_tvalid = o_valid_q;
	assign m_axis_tlast  = o_last_q;
	assign m_axis_tdata  = {total_q, o_unit_q, o_amt_q, o_hops_q, o_bar_q,
		o_snr_q, o_id_q, rank_q};

	a_valid_in_send: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> state_q == SEND)
		else $error("result valid outside send state");
	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= HELD_W'(PEER_CAPACITY))
		else $error("held count above capacity");
	a_next_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && !m_axis_tlast |=> state_q == LAUNCH)
		else $error("no next row after non-final row");
	a_finish_clear: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && s_axis_tuser |=> held_q == '0 && newest_q == 32'd0)
		else $error("table not emptied on finish");

endmodule
